FILE: rtl/cbd_pkg.sv
// shared types, constants and codes of the console cpu bus decoder
package cbd_pkg;

  localparam int unsigned RAM_BYTES_DEF  = 2048;
  localparam int unsigned DMA_LENGTH_DEF = 256;

  localparam logic [15:0] ADDR_RAM_LAST   = 16'h1FFF;
  localparam logic [15:0] ADDR_VIDEO_LAST = 16'h3FFF;
  localparam logic [15:0] ADDR_DMA_REG    = 16'h4014;
  localparam logic [15:0] ADDR_JOYPAD_0   = 16'h4016;
  localparam logic [15:0] ADDR_JOYPAD_1   = 16'h4017;
  localparam logic [15:0] ADDR_CART_BASE  = 16'h8000;

  // ram index helper splits the low 13 address bits at this point
  localparam int unsigned RAM_ADDR_BITS = 13;
  localparam int unsigned QTAB_LOW_BITS = 5;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_DMA   = 2'd2,
    FUNC_NMI   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    TGT_RAM      = 3'd0,
    TGT_VIDEO    = 3'd1,
    TGT_DMA      = 3'd2,
    TGT_JOYPAD   = 3'd3,
    TGT_CART     = 3'd4,
    TGT_UNMAPPED = 3'd5
  } target_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        nmi_level;
  } in_t;

  typedef struct packed {
    target_e     target;
    logic [14:0] target_offset;
    logic [7:0]  read_data;
    logic        dma_busy;
    logic [7:0]  oam_index;
    logic        nmi_pending;
    logic        bad_access;
  } out_t;

  // decode of one bus access
  typedef struct packed {
    target_e     target;
    logic [14:0] offset;
    logic        bad;
    logic        ram_hit;
    logic        dma_hit;
  } dec_t;

endpackage

FILE: rtl/console_cpu_bus_decoder_dma_top.sv
// top level of the console cpu bus decoder with sprite dma and nmi edge detect
//
// input channel in_valid_i / in_ready_o / in_data_i carries one bus operation per
// transaction: cpu read, cpu write, dma tick or nmi line sample. output channel
// out_valid_o / out_ready_i / out_data_o returns exactly one result transaction
// for each input transaction, in order.
// path: an accepted transaction passes the input register, then the result
// register, which is fed by the work ram read port.
// throughput: one transaction per cycle while out_ready_i is high; the single
// ram port serves one read or one write per operation, so it never lowers the rate.
// reset: rst_ni is asynchronous, active low. after reset the work ram is zeroed
// by a sweep over all RamBytes entries (2048 at the default size), one entry per
// cycle; in_ready_o stays low until the sweep is done.
// stall: when out_ready_i is low with a result waiting, the result register and
// the ram read data hold, the input register holds its operation, and
// in_ready_o drops once that register is full. ready passes straight back.
module console_cpu_bus_decoder_dma_top #(
  parameter int unsigned RamBytes  = cbd_pkg::RAM_BYTES_DEF,
  parameter int unsigned DmaLength = cbd_pkg::DMA_LENGTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cbd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cbd_pkg::out_t out_data_o
);
  import cbd_pkg::*;

  localparam int unsigned IdxW = $clog2(RamBytes);
  localparam int unsigned RemW = $clog2(DmaLength + 1);

  // ram clear sweep
  logic            clr_busy;
  logic [IdxW-1:0] clr_addr;

  cbd_ram_clear #(.Depth(RamBytes)) u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (clr_busy),
    .addr_o (clr_addr)
  );

  // pipeline registers
  logic  s1_valid_q;
  in_t   s1_q;
  logic  s2_valid_q;
  out_t  s2_q;
  logic  s2_ram_rd_q;

  // dma and nmi state
  logic [RemW-1:0] dma_rem_q, dma_rem_d;
  logic [7:0]      dma_page_q, dma_page_d;
  logic            last_nmi_q, last_nmi_d;
  logic            nmi_flag_q, nmi_flag_d;

  logic advance;
  logic process;

  // result register frees when empty or being taken
  assign advance    = !s2_valid_q || out_ready_i;
  assign in_ready_o = !clr_busy && (!s1_valid_q || advance);
  assign process    = s1_valid_q && advance;

  // work on the operation in the input register
  logic            is_cpu;
  logic            is_wr;
  logic            dma_active;
  logic            do_access;
  logic [RemW-1:0] rem_dec;
  logic [7:0]      dma_cnt;
  logic [15:0]     bus_addr;
  dec_t            dec;
  logic [IdxW-1:0] ram_idx;
  out_t            res;
  logic            res_ram_rd;

  always_comb begin
    is_cpu     = (s1_q.func == FUNC_READ) || (s1_q.func == FUNC_WRITE);
    is_wr      = (s1_q.func == FUNC_WRITE);
    dma_active = (s1_q.func == FUNC_DMA) && (dma_rem_q != '0);
    do_access  = is_cpu || dma_active;
    rem_dec    = dma_rem_q - RemW'(1);
    dma_cnt    = 8'(rem_dec);
    // dma tick reads page:count through the same decode as a cpu read
    bus_addr   = (s1_q.func == FUNC_DMA) ? {dma_page_q, dma_cnt} : s1_q.address;
  end

  cbd_addr_decode #(.RamBytes(RamBytes)) u_decode (
    .addr_i    (bus_addr),
    .wr_i      (is_wr),
    .dec_o     (dec),
    .ram_idx_o (ram_idx)
  );

  always_comb begin
    res           = '0;
    res.target    = TGT_RAM;
    res_ram_rd    = 1'b0;
    if (do_access) begin
      res.target        = dec.target;
      res.target_offset = dec.offset;
      res.bad_access    = dec.bad;
      res_ram_rd        = dec.ram_hit && !is_wr;
    end
    res.dma_busy    = dma_active;
    res.oam_index   = dma_active ? dma_cnt : 8'd0;
    res.nmi_pending = nmi_flag_d;
  end

  // state update, applied when the operation moves on
  always_comb begin
    dma_rem_d  = dma_rem_q;
    dma_page_d = dma_page_q;
    last_nmi_d = last_nmi_q;
    nmi_flag_d = nmi_flag_q;
    if (s1_valid_q) begin
      if (is_wr && dec.dma_hit) begin
        // write to the dma register restarts the transfer
        dma_rem_d  = RemW'(DmaLength);
        dma_page_d = s1_q.write_data;
      end else if (dma_active) begin
        dma_rem_d = rem_dec;
      end
      if (s1_q.func == FUNC_NMI) begin
        nmi_flag_d = s1_q.nmi_level && !last_nmi_q;
        last_nmi_d = s1_q.nmi_level;
      end
    end
  end

  // work ram, shared by the clear sweep and bus accesses
  logic            ram_en;
  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  always_comb begin
    ram_en    = clr_busy || (process && do_access && dec.ram_hit);
    ram_we    = clr_busy || is_wr;
    ram_addr  = clr_busy ? clr_addr : ram_idx;
    ram_wdata = clr_busy ? 8'd0 : s1_q.write_data;
  end

  cbd_ram #(.Width(8), .Depth(RamBytes)) u_work_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      dma_rem_q  <= '0;
      dma_page_q <= '0;
      last_nmi_q <= 1'b0;
      nmi_flag_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end else if (process) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        s2_valid_q <= s1_valid_q;
      end
      if (process) begin
        dma_rem_q  <= dma_rem_d;
        dma_page_q <= dma_page_d;
        last_nmi_q <= last_nmi_d;
        nmi_flag_q <= nmi_flag_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (process) begin
      s2_q        <= res;
      s2_ram_rd_q <= res_ram_rd;
    end
  end

  // ram read data joins the result at the output
  always_comb begin
    out_data_o           = s2_q;
    out_data_o.read_data = s2_ram_rd_q ? ram_rdata : 8'd0;
  end

  assign out_valid_o = s2_valid_q;

`ifndef ASSERT_OFF
  // no transaction enters while the ram is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ready_o)
    else $error("input accepted during ram clear");

  // nonzero read data only comes from the work ram
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.read_data != 8'd0) |-> (out_data_o.target == TGT_RAM))
    else $error("read data on a non-ram target");

  // bad access only on the dma register or unmapped space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bad_access) |->
      (out_data_o.target == TGT_DMA || out_data_o.target == TGT_UNMAPPED))
    else $error("bad access flagged on a mapped target");

  // oam index is only reported on a dma transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.dma_busy) |-> (out_data_o.oam_index == 8'd0))
    else $error("oam index without dma transfer");
`endif

endmodule

FILE: rtl/cbd_ram.sv
// generic single port ram with registered read
module cbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cbd_ram_clear.sv
// sweep that zeroes the work ram after reset
module cbd_ram_clear #(
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  output logic                     busy_o,
  output logic [$clog2(Depth)-1:0] addr_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic             busy_q, busy_d;
  logic [AddrW-1:0] addr_q, addr_d;

  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    if (busy_q) begin
      if (addr_q == LastAddr) begin
        busy_d = 1'b0;
      end else begin
        addr_d = addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = addr_q;

endmodule

FILE: rtl/cbd_addr_decode.sv
// address decode of one bus access, with the mirrored ram index
module cbd_addr_decode #(
  parameter int unsigned RamBytes = cbd_pkg::RAM_BYTES_DEF
) (
  input  logic [15:0]                 addr_i,
  input  logic                        wr_i,
  output cbd_pkg::dec_t               dec_o,
  output logic [$clog2(RamBytes)-1:0] ram_idx_o
);
  import cbd_pkg::*;

  localparam int unsigned IdxW   = $clog2(RamBytes);
  localparam int unsigned QW     = 5;
  localparam int unsigned TabLen = 2 ** (RAM_ADDR_BITS - QTAB_LOW_BITS);
  localparam logic [RAM_ADDR_BITS:0] RamBytesW = (RAM_ADDR_BITS + 1)'(RamBytes);

  // quotient estimate from the upper address bits, low by at most one
  logic [QW-1:0] qtab [TabLen];
  for (genvar g = 0; g < TabLen; g++) begin : g_qtab
    assign qtab[g] = QW'((g * (2 ** QTAB_LOW_BITS)) / RamBytes);
  end

  logic [RAM_ADDR_BITS-1:0] low_addr;
  logic [QW-1:0]            q_est;
  logic [RAM_ADDR_BITS:0]   rem0;
  logic [RAM_ADDR_BITS:0]   rem1;

  always_comb begin
    low_addr  = addr_i[RAM_ADDR_BITS-1:0];
    q_est     = qtab[low_addr[RAM_ADDR_BITS-1:QTAB_LOW_BITS]];
    rem0      = {1'b0, low_addr} - ((RAM_ADDR_BITS + 1)'(q_est) * RamBytesW);
    rem1      = (rem0 >= RamBytesW) ? (rem0 - RamBytesW) : rem0;
    ram_idx_o = rem1[IdxW-1:0];
  end

  always_comb begin
    dec_o         = '0;
    dec_o.target  = TGT_UNMAPPED;
    dec_o.offset  = addr_i[14:0];
    if (addr_i <= ADDR_RAM_LAST) begin
      dec_o.target  = TGT_RAM;
      dec_o.offset  = 15'(ram_idx_o);
      dec_o.ram_hit = 1'b1;
    end else if (addr_i <= ADDR_VIDEO_LAST) begin
      dec_o.target = TGT_VIDEO;
    end else if (addr_i == ADDR_DMA_REG) begin
      dec_o.target  = TGT_DMA;
      dec_o.dma_hit = 1'b1;
      dec_o.bad     = !wr_i;
    end else if (addr_i == ADDR_JOYPAD_0 || addr_i == ADDR_JOYPAD_1) begin
      dec_o.target = TGT_JOYPAD;
    end else if (addr_i >= ADDR_CART_BASE) begin
      // cartridge offset is address minus the base, i.e. the low 15 bits
      dec_o.target = TGT_CART;
    end else begin
      dec_o.bad = 1'b1;
    end
  end

endmodule
